// ===== design/mlsc_pkg.sv =====
// ----------------------------------------------------------------------------
// mlsc_pkg
// Shared types and constants of the monochrome LCD SPI controller: operation
// and command codes, controller states and the control/status words.
// ----------------------------------------------------------------------------
package mlsc_pkg;

    // default panel geometry
    localparam int PANEL_COLUMNS_DEF = 128;
    localparam int PANEL_ROWS_DEF    = 64;

    // operation carried with each input word
    typedef enum logic [1:0] {
        OP_SPI       = 2'd0,
        OP_RESET_PIN = 2'd1,
        OP_READ      = 2'd2,
        OP_UNUSED    = 2'd3
    } op_t;

    // command bytes and their match masks
    localparam logic [7:0] CMD_CLEAR       = 8'hE2;
    localparam logic [7:0] CMD_START_MASK  = 8'hC0;
    localparam logic [7:0] CMD_START_CODE  = 8'h40;
    localparam logic [7:0] CMD_NIBBLE_MASK = 8'hF0;
    localparam logic [7:0] CMD_PAGE_CODE   = 8'hB0;
    localparam logic [7:0] CMD_COL_HI_CODE = 8'h10;
    localparam logic [7:0] CMD_COL_LO_CODE = 8'h00;

    // class of the held word, as seen by the controller
    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2,
        ST_READ  = 2'd3
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic load_out;
        logic load_read;
        logic sweep;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  sweep_last;
        logic  out_free;
    } dp_status_t;

endpackage

// ===== design/mlsc_in_if.sv =====
// ----------------------------------------------------------------------------
// mlsc_in_if
// Input channel: one SPI byte, reset-pin pulse or frame store read per word.
// ----------------------------------------------------------------------------
interface mlsc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       chip_select_n;
    logic       data_mode;
    logic [7:0] spi_byte;
    logic [2:0] read_page;
    logic [6:0] read_column;

    modport source (
        output valid, op, chip_select_n, data_mode, spi_byte, read_page, read_column,
        input  ready
    );

    modport sink (
        input  valid, op, chip_select_n, data_mode, spi_byte, read_page, read_column,
        output ready
    );
endinterface

// ===== design/mlsc_out_if.sv =====
// ----------------------------------------------------------------------------
// mlsc_out_if
// Result channel: read byte and the address state after each word.
// ----------------------------------------------------------------------------
interface mlsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [3:0] page_now;
    logic [7:0] column_now;
    logic [4:0] start_line_now;

    modport source (
        output valid, read_data, page_now, column_now, start_line_now,
        input  ready
    );

    modport sink (
        input  valid, read_data, page_now, column_now, start_line_now,
        output ready
    );
endinterface

// ===== design/mlsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlsc_ctrl
// Controller state machine: takes a word, runs it through the datapath once
// the result register is free, and sequences the frame store clearing sweep.
// ----------------------------------------------------------------------------
module mlsc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mlsc_pkg::dp_status_t status,
    output mlsc_pkg::dp_cmd_t    cmd
);

    mlsc_pkg::state_t state_reg;
    mlsc_pkg::state_t state_next;

    // state register, reset starts with a clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlsc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            mlsc_pkg::ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = mlsc_pkg::ST_IDLE;
                end
            end
            mlsc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = mlsc_pkg::ST_EXEC;
                end
            end
            mlsc_pkg::ST_EXEC:
            begin
                if (status.out_free)
                begin
                    cmd.execute = 1'b1;
                    unique case (status.kind)
                        mlsc_pkg::KIND_READ:
                        begin
                            state_next = mlsc_pkg::ST_READ;
                        end
                        mlsc_pkg::KIND_CLEAR:
                        begin
                            cmd.load_out = 1'b1;
                            state_next   = mlsc_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            cmd.load_out = 1'b1;
                            state_next   = mlsc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            mlsc_pkg::ST_READ:
            begin
                cmd.load_read = 1'b1;
                state_next    = mlsc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/mlsc_datapath.sv =====
// ----------------------------------------------------------------------------
// mlsc_datapath
// Word holding register, address registers, command decode, frame store
// memory with clearing counter, and the result register.
// ----------------------------------------------------------------------------
module mlsc_datapath #(
    parameter int PANEL_COLUMNS = mlsc_pkg::PANEL_COLUMNS_DEF,
    parameter int PANEL_ROWS    = mlsc_pkg::PANEL_ROWS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mlsc_pkg::dp_cmd_t    cmd,
    output mlsc_pkg::dp_status_t status,
    input  logic [1:0]           op,
    input  logic                 chip_select_n,
    input  logic                 data_mode,
    input  logic [7:0]           spi_byte,
    input  logic [2:0]           read_page,
    input  logic [6:0]           read_column,
    mlsc_out_if.source           result
);

    localparam int PANEL_PAGES = (PANEL_ROWS + 7) / 8;
    localparam int CW          = $clog2(PANEL_COLUMNS);
    localparam int PW          = (PANEL_PAGES > 1) ? $clog2(PANEL_PAGES) : 1;
    localparam int AW          = PW + CW;
    localparam int MEM_DEPTH   = 1 << AW;
    localparam int LAST_ROWS   = PANEL_ROWS - (PANEL_PAGES - 1) * 8;
    localparam logic [7:0] LAST_MASK = 8'((9'd1 << LAST_ROWS) - 9'd1);

    // held word
    logic [1:0] op_reg;
    logic       csn_reg;
    logic       dm_reg;
    logic [7:0] byte_reg;
    logic [2:0] rpage_reg;
    logic [6:0] rcol_reg;

    // address state
    logic [3:0] page_reg;
    logic [3:0] page_next;
    logic [7:0] col_reg;
    logic [7:0] col_next;
    logic [4:0] start_reg;
    logic [4:0] start_next;

    // frame store
    logic [7:0]    frame_mem [MEM_DEPTH];
    logic [7:0]    mem_q_reg;
    logic [7:0]    mask_reg;
    logic [AW-1:0] sweep_cnt_reg;

    // result register
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_data_reg;
    logic [3:0] out_page_reg;
    logic [7:0] out_col_reg;
    logic [4:0] out_start_reg;

    mlsc_pkg::kind_t word_kind;
    logic            is_spi_cmd;
    logic            is_spi_data;
    logic            wr_en;
    logic            rd_ok;
    logic [7:0]      rd_mask;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    logic [3:0]      rpage_ext;
    logic [7:0]      rcol_ext;

    // capture the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            csn_reg   <= chip_select_n;
            dm_reg    <= data_mode;
            byte_reg  <= spi_byte;
            rpage_reg <= read_page;
            rcol_reg  <= read_column;
        end
    end

    // word classification
    assign is_spi_cmd  = (mlsc_pkg::op_t'(op_reg) == mlsc_pkg::OP_SPI) && !csn_reg && !dm_reg;
    assign is_spi_data = (mlsc_pkg::op_t'(op_reg) == mlsc_pkg::OP_SPI) && !csn_reg && dm_reg;

    always_comb
    begin
        if (mlsc_pkg::op_t'(op_reg) == mlsc_pkg::OP_READ)
        begin
            word_kind = mlsc_pkg::KIND_READ;
        end
        else if ((mlsc_pkg::op_t'(op_reg) == mlsc_pkg::OP_RESET_PIN)
                 || (is_spi_cmd && (byte_reg == mlsc_pkg::CMD_CLEAR)))
        begin
            word_kind = mlsc_pkg::KIND_CLEAR;
        end
        else
        begin
            word_kind = mlsc_pkg::KIND_OTHER;
        end
    end

    assign status.kind = word_kind;

    // command decode and column advance
    always_comb
    begin
        page_next  = page_reg;
        col_next   = col_reg;
        start_next = start_reg;
        if (is_spi_cmd)
        begin
            priority if ((byte_reg & mlsc_pkg::CMD_START_MASK) == mlsc_pkg::CMD_START_CODE)
            begin
                start_next = byte_reg[4:0];
            end
            else if ((byte_reg & mlsc_pkg::CMD_NIBBLE_MASK) == mlsc_pkg::CMD_PAGE_CODE)
            begin
                page_next = byte_reg[3:0];
            end
            else if ((byte_reg & mlsc_pkg::CMD_NIBBLE_MASK) == mlsc_pkg::CMD_COL_HI_CODE)
            begin
                col_next = {byte_reg[3:0], col_reg[3:0]};
            end
            else if ((byte_reg & mlsc_pkg::CMD_NIBBLE_MASK) == mlsc_pkg::CMD_COL_LO_CODE)
            begin
                col_next = {col_reg[7:4], byte_reg[3:0]};
            end
        end
        else if (is_spi_data)
        begin
            col_next = col_reg + 8'd1;
        end
    end

    // address registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg  <= '0;
            col_reg   <= '0;
            start_reg <= '0;
        end
        else if (cmd.execute)
        begin
            page_reg  <= page_next;
            col_reg   <= col_next;
            start_reg <= start_next;
        end
    end

    // store addressing and panel bounds
    assign wr_en = is_spi_data
                   && ({1'b0, page_reg} < 5'(PANEL_PAGES))
                   && ({1'b0, col_reg} < 9'(PANEL_COLUMNS));
    assign wr_addr   = {page_reg[PW-1:0], col_reg[CW-1:0]};
    assign rpage_ext = {1'b0, rpage_reg};
    assign rcol_ext  = {1'b0, rcol_reg};
    assign rd_addr   = {rpage_ext[PW-1:0], rcol_ext[CW-1:0]};
    assign rd_ok     = ({2'b0, rpage_reg} < 5'(PANEL_PAGES))
                       && ({2'b0, rcol_reg} < 9'(PANEL_COLUMNS));
    assign rd_mask   = ({2'b0, rpage_reg} == 5'(PANEL_PAGES - 1)) ? LAST_MASK : 8'hFF;

    // frame store memory, sweep clears one entry a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.sweep)
        begin
            frame_mem[sweep_cnt_reg] <= '0;
        end
        else if (cmd.execute && wr_en)
        begin
            frame_mem[wr_addr] <= byte_reg;
        end
        if (cmd.execute)
        begin
            mem_q_reg <= frame_mem[rd_addr];
            mask_reg  <= rd_ok ? rd_mask : 8'h00;
        end
    end

    // clearing sweep counter, wraps to zero after the last entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            sweep_cnt_reg <= sweep_cnt_reg + AW'(1);
        end
    end

    assign status.sweep_last = &sweep_cnt_reg;
    assign status.out_free   = !out_valid_reg || result.ready;

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out || cmd.load_read)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg  <= 8'h00;
            out_page_reg  <= page_next;
            out_col_reg   <= col_next;
            out_start_reg <= start_next;
        end
        else if (cmd.load_read)
        begin
            out_data_reg  <= mem_q_reg & mask_reg;
            out_page_reg  <= page_reg;
            out_col_reg   <= col_reg;
            out_start_reg <= start_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.read_data      = out_data_reg;
    assign result.page_now       = out_page_reg;
    assign result.column_now     = out_col_reg;
    assign result.start_line_now = out_start_reg;

endmodule

// ===== design/mono_lcd_spi_controller_core.sv =====
// ----------------------------------------------------------------------------
// mono_lcd_spi_controller_core
// Page-addressed monochrome LCD controller fed by SPI bytes, with a frame
// store that can be read back one byte at a time.
// ----------------------------------------------------------------------------
// Usage:
//   item   : input words (op, chip_select_n, data_mode, spi_byte, read_page,
//            read_column), taken when valid and ready are both high.
//   result : one word per input word (read_data, page_now, column_now,
//            start_line_now), in input order, held until ready is high.
// Results: a result is loaded when its word executes, once the result register
//   is free; a read result is loaded in the READ step, from the registered read port of the frame store.
// Flow: words are handled one at a time by the single shared execute step of
//   the controller; the next word is taken only once the last one is done.
// Clear command and reset pin: the result comes out at once, then the store
//   is swept one entry a cycle over all 2^(PW+CW) entries (1024 for a 128x64
//   panel), and item.ready stays low meanwhile.
// Reset: addresses and start line go to zero and the same sweep runs first.
// Stall: while a result waits, one more word is taken and held; it executes
//   when the result register frees up.
// ----------------------------------------------------------------------------
module mono_lcd_spi_controller_core #(
    parameter int PANEL_COLUMNS = mlsc_pkg::PANEL_COLUMNS_DEF,
    parameter int PANEL_ROWS    = mlsc_pkg::PANEL_ROWS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mlsc_in_if.sink    item,
    mlsc_out_if.source result
);

    mlsc_pkg::dp_cmd_t    cmd;
    mlsc_pkg::dp_status_t status;
    logic                 in_ready;

    assign item.ready = in_ready;

    // controller
    mlsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    mlsc_datapath #(
        .PANEL_COLUMNS (PANEL_COLUMNS),
        .PANEL_ROWS    (PANEL_ROWS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .op            (item.op),
        .chip_select_n (item.chip_select_n),
        .data_mode     (item.data_mode),
        .spi_byte      (item.spi_byte),
        .read_page     (item.read_page),
        .read_column   (item.read_column),
        .result        (result)
    );

    // no word is taken while the store is being swept
    a_no_accept_in_sweep: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.sweep |-> !item.ready
    ) else $error("word taken during clearing sweep");

    // one word at a time: a taken word blocks the next cycle
    a_one_in_flight: assert property (
        @(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready
    ) else $error("second word taken while one is in flight");

    // read data lands only in an empty result register
    a_read_slot_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.load_read |-> !result.valid
    ) else $error("read result would overwrite a pending result");

    // every executed word has its result valid, or its read data loading, in the next cycle
    a_exec_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.execute |=> result.valid || cmd.load_read
    ) else $error("executed word produced no result");

endmodule

// ===== test/mono_lcd_spi_controller_core_tb.sv =====
// ----------------------------------------------------------------------------
// mono_lcd_spi_controller_core_tb
// Self-checking bench for the LCD SPI controller. A directed list covers the
// commands, the panel edges, column wrap, deselect, clears and the reset pin.
// Random address/write/read-back bursts mixed with noise words follow. A
// local frame store model predicts every result word, and both channels idle
// and stall at random.
// ----------------------------------------------------------------------------
module mono_lcd_spi_controller_core_tb;

    localparam int COLS        = mlsc_pkg::PANEL_COLUMNS_DEF;
    localparam int ROWS        = mlsc_pkg::PANEL_ROWS_DEF;
    localparam int PAGES       = ROWS / 8;
    localparam int IDLE_PCT    = 35;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int CALM_FROM   = 1200;
    localparam int CALM_TO     = 1500;
    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        mlsc_pkg::op_t op;
        logic          chip_select_n;
        logic          data_mode;
        logic [7:0]    spi_byte;
        logic [2:0]    read_page;
        logic [6:0]    read_column;
    } lcd_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] page_now;
        logic [7:0] column_now;
        logic [4:0] start_line_now;
    } lcd_status_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // input channel drive
    logic       in_valid  = 1'b0;
    logic [1:0] in_op     = mlsc_pkg::OP_UNUSED;
    logic       in_csn    = 1'b1;
    logic       in_dm     = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic [2:0] in_page   = 3'd0;
    logic [6:0] in_column = 7'd0;
    logic       in_taken  = 1'b0;

    // result channel drive
    logic out_ready = 1'b0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;

    lcd_word_t   pending_words[$];
    lcd_status_t expected_status[$];
    int          words_queued = 0;
    int          words_in     = 0;
    int          words_out    = 0;
    int          fail_count   = 0;
    int          quiet_cycles = 0;

    // local copy of the controller state
    logic [7:0] pixel_bytes [PAGES][COLS];
    logic [3:0] page_addr  = 4'd0;
    logic [7:0] col_addr   = 8'd0;
    logic [4:0] start_line = 5'd0;

    mlsc_in_if  item_if ();
    mlsc_out_if result_if ();

    assign item_if.valid         = in_valid;
    assign item_if.op            = in_op;
    assign item_if.chip_select_n = in_csn;
    assign item_if.data_mode     = in_dm;
    assign item_if.spi_byte      = in_byte;
    assign item_if.read_page     = in_page;
    assign item_if.read_column   = in_column;
    assign result_if.ready       = out_ready;

    mono_lcd_spi_controller_core #(
        .PANEL_COLUMNS(COLS),
        .PANEL_ROWS   (ROWS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_if),
        .result(result_if)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic void clear_pixels();
        for (int p = 0; p < PAGES; p++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                pixel_bytes[p][c] = 8'h00;
            end
        end
    endfunction

    // apply one word to the local state and return the status it produces
    function automatic lcd_status_t lcd_predict(lcd_word_t w);
        lcd_status_t s;
        logic [7:0]  b;
        b = w.spi_byte;
        s.read_data = 8'h00;
        case (w.op)
            mlsc_pkg::OP_SPI:
            begin
                if (!w.chip_select_n)
                begin
                    if (!w.data_mode)
                    begin
                        if (b == mlsc_pkg::CMD_CLEAR)
                            clear_pixels();
                        else if ((b & mlsc_pkg::CMD_START_MASK) == mlsc_pkg::CMD_START_CODE)
                            start_line = b[4:0];
                        else if ((b & mlsc_pkg::CMD_NIBBLE_MASK) == mlsc_pkg::CMD_PAGE_CODE)
                            page_addr = b[3:0];
                        else if ((b & mlsc_pkg::CMD_NIBBLE_MASK) == mlsc_pkg::CMD_COL_HI_CODE)
                            col_addr[7:4] = b[3:0];
                        else if ((b & mlsc_pkg::CMD_NIBBLE_MASK) == mlsc_pkg::CMD_COL_LO_CODE)
                            col_addr[3:0] = b[3:0];
                    end
                    else
                    begin
                        // whole byte lands only on a page and column inside the panel
                        if (int'(col_addr) < COLS && int'(page_addr) < PAGES)
                            pixel_bytes[page_addr][col_addr] = b;
                        col_addr = col_addr + 8'd1;
                    end
                end
            end
            mlsc_pkg::OP_RESET_PIN:
                clear_pixels();
            mlsc_pkg::OP_READ:
                s.read_data = pixel_bytes[w.read_page][w.read_column];
            default:
                ;
        endcase
        s.page_now       = page_addr;
        s.column_now     = col_addr;
        s.start_line_now = start_line;
        return s;
    endfunction

    // stimulus helpers; unused fields carry random values
    function automatic void queue_word(mlsc_pkg::op_t op, logic csn, logic dm, logic [7:0] b,
                                       logic [2:0] pg, logic [6:0] col);
        lcd_word_t w;
        w.op            = op;
        w.chip_select_n = csn;
        w.data_mode     = dm;
        w.spi_byte      = b;
        w.read_page     = pg;
        w.read_column   = col;
        pending_words.push_back(w);
        words_queued++;
    endfunction

    function automatic void queue_spi(logic csn, logic dm, logic [7:0] b);
        queue_word(mlsc_pkg::OP_SPI, csn, dm, b, 3'($urandom), 7'($urandom));
    endfunction

    function automatic void queue_read(logic [2:0] pg, logic [6:0] col);
        queue_word(mlsc_pkg::OP_READ, 1'($urandom), 1'($urandom), 8'($urandom), pg, col);
    endfunction

    function automatic void queue_op(mlsc_pkg::op_t op);
        queue_word(op, 1'($urandom), 1'($urandom), 8'($urandom), 3'($urandom),
                   7'($urandom));
    endfunction

    function automatic void queue_random(int count);
        int         stop;
        int         pick;
        int         len;
        int         off;
        logic [3:0] pg;
        logic [7:0] col;
        logic [7:0] c;
        stop = words_queued + count;
        while (words_queued < stop)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                // address setup, a run of data, then read some of it back
                pg  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 8))
                                               : 4'($urandom_range(7));
                col = ($urandom_range(7) == 0) ? 8'($urandom_range(255, 128))
                                               : 8'($urandom_range(127));
                queue_spi(1'b0, 1'b0, mlsc_pkg::CMD_PAGE_CODE | {4'd0, pg});
                queue_spi(1'b0, 1'b0, mlsc_pkg::CMD_COL_HI_CODE | {4'd0, col[7:4]});
                queue_spi(1'b0, 1'b0, mlsc_pkg::CMD_COL_LO_CODE | {4'd0, col[3:0]});
                if ($urandom_range(3) == 0)
                    queue_spi(1'b0, 1'b0, mlsc_pkg::CMD_START_CODE | 8'($urandom_range(63)));
                len = $urandom_range(6, 1);
                repeat (len) queue_spi(1'b0, 1'b1, 8'($urandom));
                repeat ($urandom_range(3))
                begin
                    off = $urandom_range(len - 1);
                    c   = col + 8'(off);
                    queue_read(pg[2:0], c[6:0]);
                end
            end
            else if (pick < 75)
                queue_read(3'($urandom), 7'($urandom));
            else if (pick < 90)
                queue_spi(1'($urandom), 1'($urandom), 8'($urandom));
            else if (pick < 94)
                queue_op(mlsc_pkg::OP_UNUSED);
            else if (pick < 98)
                queue_spi(1'b1, 1'($urandom), 8'($urandom));
            else if (pick < 99)
                queue_spi(1'b0, 1'b0, mlsc_pkg::CMD_CLEAR);
            else
                queue_op(mlsc_pkg::OP_RESET_PIN);
        end
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_status.size() != 0);
    endtask

    // word driver
    always @(negedge clk)
    begin
        lcd_word_t w;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_words.size() != 0 &&
                ((words_in >= CALM_FROM && words_in < CALM_TO) ||
                 $urandom_range(99) >= IDLE_PCT))
            begin
                w = pending_words.pop_front();
                in_valid  <= 1'b1;
                in_op     <= w.op;
                in_csn    <= w.chip_select_n;
                in_dm     <= w.data_mode;
                in_byte   <= w.spi_byte;
                in_page   <= w.read_page;
                in_column <= w.read_column;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver, with one long hold-off
    always @(negedge clk)
    begin
        if (!hold_done && words_out >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (words_out >= CALM_FROM && words_out < CALM_TO)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // monitor: predict on each accepted word, check each result word
    always @(posedge clk)
    begin
        lcd_word_t   w;
        lcd_status_t want;
        in_taken <= item_if.valid && item_if.ready;
        if (rst_n)
        begin
            if (item_if.valid && item_if.ready)
            begin
                w.op            = mlsc_pkg::op_t'(item_if.op);
                w.chip_select_n = item_if.chip_select_n;
                w.data_mode     = item_if.data_mode;
                w.spi_byte      = item_if.spi_byte;
                w.read_page     = item_if.read_page;
                w.read_column   = item_if.read_column;
                expected_status.push_back(lcd_predict(w));
                words_in++;
            end
            if (result_if.valid && result_if.ready)
            begin
                words_out++;
                if (expected_status.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (result_if.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %0h, got %0h",
                               want.read_data, result_if.read_data);
                        fail_count++;
                    end
                    if (result_if.page_now !== want.page_now)
                    begin
                        $error("page_now: expected %0h, got %0h",
                               want.page_now, result_if.page_now);
                        fail_count++;
                    end
                    if (result_if.column_now !== want.column_now)
                    begin
                        $error("column_now: expected %0h, got %0h",
                               want.column_now, result_if.column_now);
                        fail_count++;
                    end
                    if (result_if.start_line_now !== want.start_line_now)
                    begin
                        $error("start_line_now: expected %0h, got %0h",
                               want.start_line_now, result_if.start_line_now);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (rst_n && !(item_if.valid && item_if.ready) &&
            !(result_if.valid && result_if.ready))
            quiet_cycles = quiet_cycles + 1;
        else
            quiet_cycles = 0;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("FAIL mono_lcd_spi_controller_core");
            $finish;
        end
    end

    initial
    begin
        clear_pixels();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: panel corner, outside writes, column wrap
        queue_read(3'd0, 7'd0);
        queue_spi(1'b0, 1'b0, mlsc_pkg::CMD_PAGE_CODE | 8'h07);
        queue_spi(1'b0, 1'b0, mlsc_pkg::CMD_COL_HI_CODE | 8'h07);
        queue_spi(1'b0, 1'b0, mlsc_pkg::CMD_COL_LO_CODE | 8'h0F);
        queue_spi(1'b0, 1'b1, 8'hFF);
        queue_spi(1'b0, 1'b1, 8'hA5);
        queue_read(3'd7, 7'd127);
        queue_spi(1'b0, 1'b0, mlsc_pkg::CMD_START_CODE);
        queue_spi(1'b0, 1'b0, mlsc_pkg::CMD_START_CODE | 8'h3F);
        queue_spi(1'b0, 1'b0, mlsc_pkg::CMD_START_CODE | 8'h1A);
        // deselected chip, data and clear
        queue_spi(1'b1, 1'b1, 8'h55);
        queue_spi(1'b1, 1'b0, mlsc_pkg::CMD_CLEAR);
        // page beyond the panel, then column 255 wrapping to 0
        queue_spi(1'b0, 1'b0, mlsc_pkg::CMD_PAGE_CODE | 8'h0F);
        queue_spi(1'b0, 1'b1, 8'h81);
        queue_spi(1'b0, 1'b0, mlsc_pkg::CMD_PAGE_CODE);
        queue_spi(1'b0, 1'b0, mlsc_pkg::CMD_COL_HI_CODE | 8'h0F);
        queue_spi(1'b0, 1'b0, mlsc_pkg::CMD_COL_LO_CODE | 8'h0F);
        queue_spi(1'b0, 1'b1, 8'h3C);
        queue_spi(1'b0, 1'b1, 8'h12);
        queue_read(3'd0, 7'd0);
        // commands that decode to nothing, and the unused op
        queue_spi(1'b0, 1'b0, 8'hA0);
        queue_spi(1'b0, 1'b0, 8'hFF);
        queue_spi(1'b0, 1'b0, 8'hE3);
        queue_op(mlsc_pkg::OP_UNUSED);
        queue_read(3'd7, 7'd127);
        // clear command, then reset pin
        queue_spi(1'b0, 1'b0, mlsc_pkg::CMD_CLEAR);
        queue_read(3'd7, 7'd127);
        queue_spi(1'b0, 1'b1, 8'h99);
        queue_op(mlsc_pkg::OP_RESET_PIN);
        queue_read(3'd0, 7'd1);
        wait_drained();

        // random bursts, with a full drain between the two halves
        @(posedge clk);
        queue_random(1000);
        wait_drained();
        @(posedge clk);
        queue_random(1000);
        wait_drained();

        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("PASS mono_lcd_spi_controller_core");
        else
            $display("FAIL mono_lcd_spi_controller_core");
        $finish;
    end

endmodule
